// File: rtl/ljpf_pkg.sv
package ljpf_pkg;

   typedef enum logic [1:0] {
      CSR_BOX_LENGTH       = 2'd0,
      CSR_CUTOFF_SQUARED   = 2'd1,
      CSR_REPULSIVE_COEFF  = 2'd2,
      CSR_ATTRACTIVE_COEFF = 2'd3
   } csr_index_type;

   localparam logic [30:0] BOX_LENGTH_RESET     = 31'd20971520;
   localparam logic [47:0] CUTOFF_SQUARED_RESET = 48'd1212153856;

   localparam int DIV_STAGES = 64;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;
   localparam logic [CNT_W-1:0] FIFO_COUNT_MAX = CNT_W'(FIFO_DEPTH);

   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT64_MIN  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] FFAC_LIMIT = ALL_ONES / 64'd6;

   typedef struct packed {
      logic             in_range;
      logic [2:0]       neg;
      logic [2:0][31:0] mag;
   } item_type;

   typedef struct packed {
      item_type    item;
      logic [47:0] divisor;
   } pair_type;

   typedef struct packed {
      item_type    item;
      logic [63:0] rinv;
      logic [63:0] r2;
      logic [63:0] r6;
      logic [63:0] av;
      logic [63:0] edif;
      logic [63:0] gmag;
      logic [63:0] emag;
      logic [63:0] m1;
      logic [63:0] ffac;
      logic        eneg;
      logic        gneg;
   } stage_type;

   // product >> s, saturated to 64 bits
   function automatic logic [63:0] shr_sat(input logic [127:0] p, input int s);
      logic [127:0] sh;
      sh = p >> s;
      return (sh[127:64] != 64'd0) ? ALL_ONES : sh[63:0];
   endfunction

   function automatic logic [63:0] signed_out(input logic [63:0] mag, input logic neg);
      logic [63:0] m;
      if (!neg) begin
         return (mag > INT64_MAX) ? INT64_MAX : mag;
      end
      m = (mag > INT64_MIN) ? INT64_MIN : mag;
      return 64'd0 - m;
   endfunction

endpackage

// File: rtl/ljpf_front.sv
module ljpf_front import ljpf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [30:0]      box_length,
   input  logic [47:0]      cutoff_squared,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [2:0][31:0] first_pos,
   input  logic [2:0][31:0] second_pos,
   output logic             out_valid,
   input  logic             out_ready,
   output pair_type         out_data
);

   logic             enable;
   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [2:0][32:0] diff_ff, diff_in;
   item_type         s2_item_ff, s2_item_in;
   item_type         s3_item_ff;
   logic [2:0][63:0] sq_ff, sq_in;
   pair_type         pair_ff, pair_in;

   assign enable    = !s4_vld_ff || out_ready;
   assign in_ready  = enable;
   assign out_valid = s4_vld_ff;
   assign out_data  = pair_ff;

   always_comb begin
      logic signed [33:0] twice, boxs, dd, cd, absv;
      logic [49:0] rsq;
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = {first_pos[k][31], first_pos[k]} - {second_pos[k][31], second_pos[k]};
      end
      s2_item_in = '0;
      boxs = $signed({3'b000, box_length});
      for (int k = 0; k < 3; k++) begin
         twice = $signed({diff_ff[k], 1'b0});
         dd    = $signed({diff_ff[k][32], diff_ff[k]});
         if (twice > boxs) begin
            cd = dd - boxs;
         end else if (twice < -boxs) begin
            cd = dd + boxs;
         end else begin
            cd = dd;
         end
         absv = cd[33] ? -cd : cd;
         s2_item_in.neg[k] = cd[33];
         s2_item_in.mag[k] = absv[31:0];
      end
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = s2_item_ff.mag[k] * s2_item_ff.mag[k];
      end
      rsq = {2'b00, sq_ff[0][63:16]} + {2'b00, sq_ff[1][63:16]} + {2'b00, sq_ff[2][63:16]};
      pair_in = '0;
      pair_in.item = s3_item_ff;
      pair_in.item.in_range = rsq < {2'b00, cutoff_squared};
      pair_in.divisor = (!pair_in.item.in_range || rsq == 50'd0) ? 48'd1 : rsq[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (enable) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         diff_ff    <= diff_in;
         s2_item_ff <= s2_item_in;
         s3_item_ff <= s2_item_ff;
         sq_ff      <= sq_in;
         pair_ff    <= pair_in;
      end
   end

`ifndef SYNTH
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> pair_ff.divisor != 48'd0)
      else $error("zero divisor handed to back end");
`endif

endmodule

// File: rtl/ljpf_fifo.sv
module ljpf_fifo import ljpf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pair_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pair_type out_data
);

   pair_type               mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = count_ff != FIFO_COUNT_MAX;
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_COUNT_MAX)
      else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FIFO_COUNT_MAX) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/ljpf_div.sv
module ljpf_div import ljpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        in_valid,
   input  logic [47:0] in_divisor,
   input  item_type    in_item,
   output logic        out_valid,
   output logic [63:0] out_quotient,
   output item_type    out_item
);

   // restoring division of all ones by the divisor, one quotient bit a stage
   logic        vld_ff [DIV_STAGES];
   logic [47:0] rem_ff [DIV_STAGES];
   logic [47:0] rem_in [DIV_STAGES];
   logic [63:0] quo_ff [DIV_STAGES];
   logic [63:0] quo_in [DIV_STAGES];
   logic [47:0] dvs_ff [DIV_STAGES];
   item_type    itm_ff [DIV_STAGES];

   assign out_valid    = vld_ff[DIV_STAGES-1];
   assign out_quotient = quo_ff[DIV_STAGES-1];
   assign out_item     = itm_ff[DIV_STAGES-1];

   always_comb begin
      logic [47:0] prem, pdvs;
      logic [63:0] pquo;
      logic [48:0] trial;
      for (int i = 0; i < DIV_STAGES; i++) begin
         if (i == 0) begin
            prem = '0;
            pquo = '0;
            pdvs = in_divisor;
         end else begin
            prem = rem_ff[i-1];
            pquo = quo_ff[i-1];
            pdvs = dvs_ff[i-1];
         end
         trial = {prem, 1'b1};
         if (trial >= {1'b0, pdvs}) begin
            rem_in[i] = 48'(trial - {1'b0, pdvs});
            quo_in[i] = {pquo[62:0], 1'b1};
         end else begin
            rem_in[i] = trial[47:0];
            quo_in[i] = {pquo[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < DIV_STAGES; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
         dvs_ff[0] <= in_divisor;
         itm_ff[0] <= in_item;
         for (int i = 1; i < DIV_STAGES; i++) begin
            dvs_ff[i] <= dvs_ff[i-1];
            itm_ff[i] <= itm_ff[i-1];
         end
      end
   end

`ifndef SYNTH
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> rem_ff[0] < dvs_ff[0] || dvs_ff[0] == 48'd0)
      else $error("divider remainder out of range");
`endif

endmodule

// File: rtl/ljpf_mul.sv
module ljpf_mul (
   input  logic         clock,
   input  logic         enable,
   input  logic [63:0]  mul_a,
   input  logic [63:0]  mul_b,
   output logic [127:0] product
);

   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] prod_ff;

   assign product = prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff   <= mul_a[31:0] * mul_b[31:0];
         lh_ff   <= mul_a[31:0] * mul_b[63:32];
         hl_ff   <= mul_a[63:32] * mul_b[31:0];
         hh_ff   <= mul_a[63:32] * mul_b[63:32];
         prod_ff <= {hh_ff, ll_ff} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0};
      end
   end

endmodule

// File: rtl/ljpf_back.sv
module ljpf_back import ljpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [47:0] repulsive_coeff,
   input  logic [47:0] attractive_coeff,
   input  logic        in_valid,
   output logic        in_ready,
   input  pair_type    in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [63:0] force_x,
   output logic [63:0] force_y,
   output logic [63:0] force_z,
   output logic [63:0] pair_energy,
   output logic        within_cutoff
);

   localparam int NSTG = 18;

   logic             adv;
   logic             dv_vld;
   logic [63:0]      dv_quo;
   item_type         dv_item;
   stage_type        st_ff [1:NSTG];
   stage_type        st_in [1:NSTG];
   logic             vld_ff [1:NSTG];
   logic [127:0]     p_r2, p_r6, p_rep, p_en, p_g, p_m2;
   logic [2:0][127:0] p_f;
   logic             res_vld_ff;
   logic [63:0]      fx_ff, fy_ff, fz_ff, en_ff, fx_in, fy_in, fz_in, en_in;
   logic             wc_ff, wc_in;

   assign adv           = !res_vld_ff || out_ready;
   assign in_ready      = adv;
   assign out_valid     = res_vld_ff;
   assign force_x       = fx_ff;
   assign force_y       = fy_ff;
   assign force_z       = fz_ff;
   assign pair_energy   = en_ff;
   assign within_cutoff = wc_ff;

   ljpf_div u_div (
      .clock        (clock),
      .reset        (reset),
      .enable       (adv),
      .in_valid     (in_valid),
      .in_divisor   (in_data.divisor),
      .in_item      (in_data.item),
      .out_valid    (dv_vld),
      .out_quotient (dv_quo),
      .out_item     (dv_item)
   );

   ljpf_mul u_mul_r2 (.clock(clock), .enable(adv), .mul_a(dv_quo), .mul_b(dv_quo),
                      .product(p_r2));
   ljpf_mul u_mul_r6 (.clock(clock), .enable(adv), .mul_a(st_ff[3].r2),
                      .mul_b(st_ff[3].rinv), .product(p_r6));
   ljpf_mul u_mul_rep (.clock(clock), .enable(adv), .mul_a({16'd0, repulsive_coeff}),
                       .mul_b(st_ff[6].r6), .product(p_rep));
   ljpf_mul u_mul_en (.clock(clock), .enable(adv), .mul_a(st_ff[10].edif),
                      .mul_b(st_ff[10].r6), .product(p_en));
   ljpf_mul u_mul_g (.clock(clock), .enable(adv), .mul_a(st_ff[10].gmag),
                     .mul_b(st_ff[10].r6), .product(p_g));
   ljpf_mul u_mul_m2 (.clock(clock), .enable(adv), .mul_a(st_ff[13].m1),
                      .mul_b(st_ff[13].rinv), .product(p_m2));

   for (genvar k = 0; k < 3; k++) begin : g_force
      ljpf_mul u_mul_f (.clock(clock), .enable(adv), .mul_a({32'd0, st_ff[16].item.mag[k]}),
                        .mul_b(st_ff[16].ffac), .product(p_f[k]));
   end

   always_comb begin
      logic [63:0] c6q, a_sat, av, a2, m2;
      stage_type   last;
      c6q = {attractive_coeff, 16'd0};
      st_in[1]      = '0;
      st_in[1].item = dv_item;
      st_in[1].rinv = dv_quo;
      for (int i = 2; i <= NSTG; i++) begin
         st_in[i] = st_ff[i-1];
      end
      st_in[3].r2 = shr_sat(p_r2, 40);
      st_in[6].r6 = shr_sat(p_r6, 40);
      a_sat = shr_sat(p_rep, 24);
      st_in[9].av = a_sat[63] ? INT64_MAX : a_sat;
      av = st_ff[9].av;
      a2 = {av[62:0], 1'b0};
      st_in[10].eneg = av < c6q;
      st_in[10].edif = (av < c6q) ? c6q - av : av - c6q;
      st_in[10].gneg = a2 < c6q;
      st_in[10].gmag = (a2 < c6q) ? c6q - a2 : a2 - c6q;
      st_in[13].emag = shr_sat(p_en, 40);
      st_in[13].m1   = shr_sat(p_g, 32);
      m2 = shr_sat(p_m2, 48);
      st_in[16].ffac = (m2 > FFAC_LIMIT) ? ALL_ONES : (m2 << 2) + (m2 << 1);

      last  = st_ff[NSTG];
      wc_in = last.item.in_range;
      if (last.item.in_range) begin
         fx_in = signed_out(shr_sat(p_f[0], 20), last.item.neg[0] != last.gneg);
         fy_in = signed_out(shr_sat(p_f[1], 20), last.item.neg[1] != last.gneg);
         fz_in = signed_out(shr_sat(p_f[2], 20), last.item.neg[2] != last.gneg);
         en_in = signed_out(last.emag, last.eneg);
      end else begin
         fx_in = '0;
         fy_in = '0;
         fz_in = '0;
         en_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= NSTG; i++) begin
            vld_ff[i] <= 1'b0;
         end
         res_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= dv_vld;
         for (int i = 2; i <= NSTG; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         res_vld_ff <= vld_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 1; i <= NSTG; i++) begin
            st_ff[i] <= st_in[i];
         end
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         fz_ff <= fz_in;
         en_ff <= en_in;
         wc_ff <= wc_in;
      end
   end

`ifndef SYNTH
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      res_vld_ff && !wc_ff |-> fx_ff == '0 && fy_ff == '0 && fz_ff == '0 && en_ff == '0)
      else $error("nonzero result outside cutoff");
`endif

endmodule

// File: rtl/lennard_jones_pair_force_core.sv
// A req passes the front stages, the queue, the divider and the back stages to rsp_tvalid.
// Throughput: one pair per cycle while rsp_tready is high; the 64-stage reciprocal divider
// and the multipliers are fully pipelined, and a 4-entry queue decouples front and back.
// Reset: synchronous, active high; clears all valid bits and the queue, and loads
// box_length = 20.0, cutoff_squared = 1212153856 and zero coefficients.
module lennard_jones_pair_force_core import ljpf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [47:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z
   input  logic [191:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, force_z, pair_energy
   output logic [255:0] rsp_tdata,
   // within_cutoff
   output logic         rsp_tuser
);

   logic [30:0]      box_length_ff;
   logic [47:0]      cutoff_squared_ff, repulsive_coeff_ff, attractive_coeff_ff;
   logic [2:0][31:0] first_pos, second_pos;
   logic             fr_valid, fr_ready, bk_valid, bk_ready;
   pair_type         fr_data, bk_data;
   logic [63:0]      force_x, force_y, force_z, pair_energy;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_length_ff       <= BOX_LENGTH_RESET;
         cutoff_squared_ff   <= CUTOFF_SQUARED_RESET;
         repulsive_coeff_ff  <= '0;
         attractive_coeff_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_LENGTH:       box_length_ff       <= csr_wdata[30:0];
            CSR_CUTOFF_SQUARED:   cutoff_squared_ff   <= csr_wdata;
            CSR_REPULSIVE_COEFF:  repulsive_coeff_ff  <= csr_wdata;
            CSR_ATTRACTIVE_COEFF: attractive_coeff_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign first_pos  = req_tdata[95:0];
   assign second_pos = req_tdata[191:96];

   ljpf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .box_length     (box_length_ff),
      .cutoff_squared (cutoff_squared_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .first_pos      (first_pos),
      .second_pos     (second_pos),
      .out_valid      (fr_valid),
      .out_ready      (fr_ready),
      .out_data       (fr_data)
   );

   ljpf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_data)
   );

   ljpf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .repulsive_coeff  (repulsive_coeff_ff),
      .attractive_coeff (attractive_coeff_ff),
      .in_valid         (bk_valid),
      .in_ready         (bk_ready),
      .in_data          (bk_data),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .force_x          (force_x),
      .force_y          (force_y),
      .force_z          (force_z),
      .pair_energy      (pair_energy),
      .within_cutoff    (rsp_tuser)
   );

   assign rsp_tdata = {pair_energy, force_z, force_y, force_x};

endmodule
